>>> src/jels_pkg.sv
// Shared types and constants for the JSON element length scanner.
package jels_pkg;

    localparam longint unsigned MAX_LENGTH = 64'd65535;
    localparam int unsigned     MAX_DEPTH  = 32'd255;

    localparam int unsigned LEN_W   = 16;
    localparam int unsigned DEPTH_W = 8;
    localparam int unsigned BYTE_W  = 8;

    // Effective limits, clamped to what the length and depth counters hold
    localparam logic [LEN_W-1:0] LEN_LIMIT =
        LEN_W'((MAX_LENGTH < 64'd65535) ? MAX_LENGTH : 64'd65535);
    localparam logic [DEPTH_W-1:0] DEPTH_LIMIT =
        DEPTH_W'((MAX_DEPTH < 32'd255) ? MAX_DEPTH : 32'd255);

    localparam logic [BYTE_W-1:0] CH_NUL       = 8'h00;
    localparam logic [BYTE_W-1:0] CH_QUOTE     = 8'h22;
    localparam logic [BYTE_W-1:0] CH_LBRACE    = 8'h7B;
    localparam logic [BYTE_W-1:0] CH_RBRACE    = 8'h7D;
    localparam logic [BYTE_W-1:0] CH_LBRACKET  = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_RBRACKET  = 8'h5D;
    localparam logic [BYTE_W-1:0] CH_COMMA     = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_BACKSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_SPACE     = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB       = 8'h09;
    localparam logic [BYTE_W-1:0] CH_CR        = 8'h0D;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_STRING = 2'd1,
        MODE_NESTED = 2'd2,
        MODE_SCALAR = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_COMPLETE     = 2'd0,
        ST_UNTERMINATED = 2'd1,
        ST_EMPTY        = 2'd2,
        ST_OVERFLOW     = 2'd3
    } t_status;

    typedef struct packed {
        logic             hit;
        logic [LEN_W-1:0] length;
        t_status          status;
    } t_result;

endpackage

>>> src/jels_if.sv
// Byte and result channel interfaces for the JSON element length scanner.
interface jels_byte_if import jels_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              start_req;
    logic [BYTE_W-1:0] text_byte;

    modport source (output valid, output start_req, output text_byte, input ready);
    modport sink   (input valid, input start_req, input text_byte, output ready);
endinterface

interface jels_len_if import jels_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] length;
    logic [1:0]       status;

    modport source (output valid, output length, output status, input ready);
    modport sink   (input valid, input length, input status, output ready);
endinterface

>>> src/jels_scan_core.sv
// Scan state registers and the per-byte update of the JSON element scanner.
module jels_scan_core import jels_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic              i_start,
    input  logic [BYTE_W-1:0] i_byte,
    output t_result           o_res
);

    t_mode              r_mode,    n_mode;
    logic               r_brace,   n_brace;
    logic               r_quote,   n_quote;
    logic               r_prev_bs, n_prev_bs;
    logic [DEPTH_W-1:0] r_depth,   n_depth;
    logic [LEN_W-1:0]   r_pos,     n_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_IDLE;
            r_brace   <= 1'b0;
            r_quote   <= 1'b0;
            r_prev_bs <= 1'b0;
            r_depth   <= '0;
            r_pos     <= '0;
        end else begin
            r_mode    <= n_mode;
            r_brace   <= n_brace;
            r_quote   <= n_quote;
            r_prev_bs <= n_prev_bs;
            r_depth   <= n_depth;
            r_pos     <= n_pos;
        end
    end

    always_comb begin
        logic               fin;
        logic [LEN_W-1:0]   fin_len;
        t_status            fin_st;
        logic [LEN_W-1:0]   pos_inc;
        logic [DEPTH_W-1:0] depth_dec;
        logic               is_stop;
        logic [BYTE_W-1:0]  open_ch;
        logic [BYTE_W-1:0]  close_ch;

        n_mode    = r_mode;
        n_brace   = r_brace;
        n_quote   = r_quote;
        n_prev_bs = r_prev_bs;
        n_depth   = r_depth;
        n_pos     = r_pos;
        fin       = 1'b0;
        fin_len   = r_pos;
        fin_st    = ST_COMPLETE;
        pos_inc   = r_pos + LEN_W'(1);
        depth_dec = (r_depth != '0) ? r_depth - DEPTH_W'(1) : r_depth;
        open_ch   = r_brace ? CH_LBRACE : CH_LBRACKET;
        close_ch  = r_brace ? CH_RBRACE : CH_RBRACKET;
        is_stop   = (i_byte == CH_COMMA) || (i_byte == CH_RBRACKET) ||
                    (i_byte == CH_RBRACE) || (i_byte == CH_SPACE) ||
                    ((i_byte >= CH_TAB) && (i_byte <= CH_CR));

        if (i_step) begin
            if (i_start) begin
                // restart: drop any running scan
                n_mode    = MODE_IDLE;
                n_quote   = 1'b0;
                n_depth   = '0;
                n_brace   = 1'b0;
                n_pos     = '0;
                n_prev_bs = 1'b0;
                if (i_byte == CH_NUL) begin
                    fin     = 1'b1;
                    fin_len = '0;
                    fin_st  = ST_EMPTY;
                end else begin
                    n_pos     = LEN_W'(1);
                    n_prev_bs = (i_byte == CH_BACKSLASH);
                    if (i_byte == CH_QUOTE) begin
                        n_mode = MODE_STRING;
                    end else if (i_byte == CH_LBRACE || i_byte == CH_LBRACKET) begin
                        n_mode  = MODE_NESTED;
                        n_brace = (i_byte == CH_LBRACE);
                        n_depth = DEPTH_W'(1);
                    end else begin
                        n_mode = MODE_SCALAR;
                    end
                end
            end else if (r_mode != MODE_IDLE) begin
                if (r_mode == MODE_SCALAR && (i_byte == CH_NUL || is_stop)) begin
                    fin = 1'b1;
                end else if (i_byte == CH_NUL) begin
                    fin    = 1'b1;
                    fin_st = ST_UNTERMINATED;
                end else if (r_pos >= LEN_LIMIT) begin
                    fin    = 1'b1;
                    fin_st = ST_OVERFLOW;
                end else begin
                    n_pos   = pos_inc;
                    fin_len = pos_inc;
                    if (r_mode == MODE_STRING) begin
                        if (i_byte == CH_QUOTE && !r_prev_bs) begin
                            fin = 1'b1;
                        end
                    end else if (r_mode == MODE_NESTED) begin
                        if (r_quote) begin
                            if (i_byte == CH_QUOTE) begin
                                n_quote = 1'b0;
                            end
                        end else if (i_byte == CH_QUOTE) begin
                            n_quote = 1'b1;
                        end else if (i_byte == open_ch) begin
                            if (r_depth >= DEPTH_LIMIT) begin
                                fin    = 1'b1;
                                fin_st = ST_OVERFLOW;
                            end else begin
                                n_depth = r_depth + DEPTH_W'(1);
                            end
                        end else if (i_byte == close_ch && !r_prev_bs) begin
                            n_depth = depth_dec;
                            if (depth_dec == '0) begin
                                fin = 1'b1;
                            end
                        end
                    end
                    n_prev_bs = (i_byte == CH_BACKSLASH);
                end
            end
        end

        if (fin) begin
            n_mode  = MODE_IDLE;
            n_quote = 1'b0;
            n_depth = '0;
        end

        o_res.hit    = fin;
        o_res.length = fin_len;
        o_res.status = fin_st;
    end

    a_result_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.hit |=> r_mode == MODE_IDLE)
        else $error("scan did not return to idle after a result");

    a_idle_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && !i_start && r_mode == MODE_IDLE) |-> !o_res.hit)
        else $error("result from a byte outside any element");

    a_depth_nested: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode != MODE_NESTED) |-> (r_depth == '0 && !r_quote))
        else $error("nesting state left over outside a nested scan");

    a_pos_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= LEN_LIMIT)
        else $error("byte position beyond the length limit");

endmodule

>>> src/json_element_length_scanner.sv
// A byte goes to the input register; the result it ends goes to the result register.
// Throughput: one byte per cycle while the output is not held; the input register and
//   result register let a new byte transfer while a finished result still waits at the output.
// The combinational per-byte update of scan mode, depth and byte position sets that rate.
// Reset (i_rst_n low, synchronous) returns the scan to idle and empties both registers.
// Top level of the JSON element length scanner.
module json_element_length_scanner import jels_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    jels_byte_if.sink   i_text,
    jels_len_if.source  o_len
);

    logic              r_in_valid;
    logic              r_in_start;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_valid;
    logic [LEN_W-1:0]  r_out_len;
    t_status           r_out_status;
    logic              advance;
    logic              step;
    t_result           res;

    // Advance the scan stage whenever the result register is free or being drained
    assign advance      = !r_out_valid || o_len.ready;
    assign step         = r_in_valid && advance;
    assign i_text.ready = !r_in_valid || advance;

    // Input register: hold the byte until the scan stage takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_text.valid && i_text.ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_text.valid && i_text.ready) begin
            r_in_start <= i_text.start_req;
            r_in_byte  <= i_text.text_byte;
        end
    end

    jels_scan_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_start (r_in_start),
        .i_byte  (r_in_byte),
        .o_res   (res)
    );

    // Result register: load only when the step ends an element
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= step && res.hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && res.hit) begin
            r_out_len    <= res.length;
            r_out_status <= res.status;
        end
    end

    assign o_len.valid  = r_out_valid;
    assign o_len.length = r_out_len;
    assign o_len.status = r_out_status;

endmodule
